@@ src/dfsle_pkg.sv @@
package dfsle_pkg;

  localparam int MAX_NODES = 64;
  localparam int RANK_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = 7;
  localparam int GRID_W    = 3;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // incoming command codes
  localparam logic [2:0] CMD_CODE_START   = 3'd0;
  localparam logic [2:0] CMD_CODE_PROBE   = 3'd1;
  localparam logic [2:0] CMD_CODE_ALREADY = 3'd2;
  localparam logic [2:0] CMD_CODE_PARENT  = 3'd3;
  localparam logic [2:0] CMD_CODE_CHECK   = 3'd4;

  // outgoing message kinds
  localparam logic [1:0] KIND_PROBE   = 2'd0;
  localparam logic [1:0] KIND_PARENT  = 2'd1;
  localparam logic [1:0] KIND_ALREADY = 2'd2;
  localparam logic [1:0] KIND_TERM    = 2'd3;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NBR_MASK = 2'd2;

  typedef enum logic [2:0] {
    CMD_START,
    CMD_PROBE,
    CMD_ALREADY,
    CMD_PARENT,
    CMD_CHECK,
    CMD_NONE
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [RANK_W-1:0] sender;
    logic [RANK_W-1:0] leader;
  } item_t;

  typedef struct packed {
    logic              send_valid;
    logic [1:0]        send_kind;
    logic [RANK_W-1:0] send_dest;
    logic [RANK_W-1:0] send_leader;
    logic [RANK_W-1:0] send_origin;
    logic              leader_known;
    logic [RANK_W-1:0] current_leader;
    logic              done;
  } res_t;

endpackage

@@ src/dfs_leader_election_node_unit.sv @@
// One node of a depth-first leader election. Each word on the in_ channel is
// one received event (start, leader probe, already reply, parent reply or
// termination check) and yields exactly one word on the out_ channel: at most
// one outgoing message (probe, parent reply, already reply or terminate
// report, with all send_ fields zero when nothing is sent) plus the node's
// leader and done status after the event. The block runs at one word per
// clock unless out_ready holds the output register: the front decodes the
// command into a two-entry queue, and the back applies the event to the node
// state and loads the output register in the same cycle it pops the queue,
// so each word passes through a queue entry and then the output register.
// The back's update includes a priority encoder over the 64-bit unexplored
// set. The output register is released while it is being read, so a
// continuously ready sink sees no bubbles.
// node_id, grid_dim and neighbor_mask are written through cfg_we/cfg_idx/
// cfg_wdata and may only change while no word is in flight.
module dfs_leader_election_node_unit
  import dfsle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_command,
  input  logic [RANK_W-1:0]    in_sender,
  input  logic [RANK_W-1:0]    in_msg_leader,
  input  logic [RANK_W-1:0]    in_msg_origin,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_send_valid,
  output logic [1:0]           out_send_kind,
  output logic [RANK_W-1:0]    out_send_dest,
  output logic [RANK_W-1:0]    out_send_leader,
  output logic [RANK_W-1:0]    out_send_origin,
  output logic                 out_leader_known,
  output logic [RANK_W-1:0]    out_current_leader,
  output logic                 out_done_res,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  item_t dec_item;
  item_t q_head;
  logic  q_full;
  logic  q_nonempty;
  logic  q_pop;
  logic  push;
  res_t  res;

  // msg_origin carries no meaning for this node's decisions
  dfsle_front u_front (
    .command    (in_command),
    .sender     (in_sender),
    .msg_leader (in_msg_leader),
    .item       (dec_item)
  );

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // decouples decode from the state update
  dfsle_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (dec_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  // node state, exploration and output register
  dfsle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign out_send_valid     = res.send_valid;
  assign out_send_kind      = res.send_kind;
  assign out_send_dest      = res.send_dest;
  assign out_send_leader    = res.send_leader;
  assign out_send_origin    = res.send_origin;
  assign out_leader_known   = res.leader_known;
  assign out_current_leader = res.current_leader;
  assign out_done_res       = res.done;

endmodule

@@ src/dfsle_front.sv @@
module dfsle_front
  import dfsle_pkg::*;
(
  input  logic [2:0]        command,
  input  logic [RANK_W-1:0] sender,
  input  logic [RANK_W-1:0] msg_leader,
  output item_t             item
);

  cmd_t cmd;

  always_comb begin
    unique case (command)
      CMD_CODE_START:   cmd = CMD_START;
      CMD_CODE_PROBE:   cmd = CMD_PROBE;
      CMD_CODE_ALREADY: cmd = CMD_ALREADY;
      CMD_CODE_PARENT:  cmd = CMD_PARENT;
      CMD_CODE_CHECK:   cmd = CMD_CHECK;
      default:          cmd = CMD_NONE;
    endcase
  end

  assign item.cmd    = cmd;
  assign item.sender = sender;
  assign item.leader = msg_leader;

endmodule

@@ src/dfsle_queue.sv @@
module dfsle_queue
  import dfsle_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  nonempty,
  output item_t head
);

  item_t      mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  assign full     = (count_r == 2'd2);
  assign nonempty = (count_r != 2'd0);
  assign head     = mem[rd_ptr_r];

endmodule

@@ src/dfsle_back.sv @@
module dfsle_back
  import dfsle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 q_nonempty,
  input  item_t                q_head,
  output logic                 q_pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_t                 res
);

  // configuration
  logic [RANK_W-1:0]    node_id_r;
  logic [GRID_W-1:0]    grid_dim_r;
  logic [MAX_NODES-1:0] nbr_mask_r;

  // election state
  logic                 lv_r, lv_nxt;
  logic [RANK_W-1:0]    lid_r, lid_nxt;
  logic                 pv_r, pv_nxt;
  logic [RANK_W-1:0]    pid_r, pid_nxt;
  logic [MAX_NODES-1:0] unexp_r, unexp_nxt;
  logic [CNT_W-1:0]     probes_r, probes_nxt;
  logic [CNT_W-1:0]     replies_r, replies_nxt;
  logic                 active_r, active_nxt;
  logic                 term_r, term_nxt;

  logic                 out_valid_r;
  res_t                 res_r, res_nxt;

  logic [RANK_W-1:0]    grid_sq;
  logic [MAX_NODES-1:0] valid_ranks;
  logic [MAX_NODES-1:0] base_set;
  logic                 match;
  logic                 do_explore;
  logic [MAX_NODES-1:0] pre_set;
  logic [CNT_W-1:0]     pre_probes;
  logic [MAX_NODES-1:0] low_onehot;
  logic [RANK_W-1:0]    low_idx;

  assign q_pop = q_nonempty && (!out_valid_r || res_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r  <= RANK_W'(1);
      grid_dim_r <= GRID_W'(1);
      nbr_mask_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_NODE_ID:  node_id_r  <= cfg_wdata[RANK_W-1:0];
        CFG_GRID_DIM: grid_dim_r <= cfg_wdata[GRID_W-1:0];
        CFG_NBR_MASK: nbr_mask_r <= cfg_wdata[MAX_NODES-1:0];
        default: ;
      endcase
    end
  end

  // ranks 1 .. min(grid_dim^2, MAX_NODES-1)
  always_comb begin
    grid_sq = RANK_W'({{(RANK_W-GRID_W){1'b0}}, grid_dim_r}
                      * {{(RANK_W-GRID_W){1'b0}}, grid_dim_r});
    for (int i = 0; i < MAX_NODES; i++) begin
      valid_ranks[i] = (i != 0) && ((RANK_W+1)'(i) <= {1'b0, grid_sq});
    end
    base_set = nbr_mask_r & valid_ranks;
  end

  assign match = lv_r && (lid_r == q_head.leader);

  // event handling, then the shared exploration step
  always_comb begin
    lv_nxt      = lv_r;
    lid_nxt     = lid_r;
    pv_nxt      = pv_r;
    pid_nxt     = pid_r;
    replies_nxt = replies_r;
    active_nxt  = active_r;
    term_nxt    = term_r;
    pre_set     = unexp_r;
    pre_probes  = probes_r;
    do_explore  = 1'b0;

    res_nxt = '0;

    case (q_head.cmd)
      CMD_START: begin
        lv_nxt      = 1'b1;
        lid_nxt     = node_id_r;
        pv_nxt      = 1'b1;
        pid_nxt     = node_id_r;
        pre_set     = base_set;
        pre_probes  = '0;
        replies_nxt = '0;
        active_nxt  = 1'b1;
        term_nxt    = 1'b0;
        do_explore  = 1'b1;
      end
      CMD_PROBE: begin
        if (term_r) begin
          if (match) begin
            res_nxt.send_valid  = 1'b1;
            res_nxt.send_kind   = KIND_ALREADY;
            res_nxt.send_dest   = q_head.sender;
            res_nxt.send_leader = lid_r;
            res_nxt.send_origin = node_id_r;
          end
        end else if (!lv_r || q_head.leader > lid_r) begin
          // takeover when no leader is known or by a higher leader
          lv_nxt      = 1'b1;
          lid_nxt     = q_head.leader;
          pv_nxt      = 1'b1;
          pid_nxt     = q_head.sender;
          pre_set     = base_set & ~(MAX_NODES'(1) << q_head.sender);
          pre_probes  = '0;
          replies_nxt = '0;
          active_nxt  = 1'b1;
          term_nxt    = 1'b0;
          do_explore  = 1'b1;
        end else if (match) begin
          res_nxt.send_valid  = 1'b1;
          res_nxt.send_kind   = KIND_ALREADY;
          res_nxt.send_dest   = q_head.sender;
          res_nxt.send_leader = lid_r;
          res_nxt.send_origin = node_id_r;
        end
      end
      CMD_ALREADY: begin
        if (!term_r && match) begin
          if (probes_r != '0) begin
            pre_probes = probes_r - CNT_W'(1);
          end
          do_explore = 1'b1;
        end
      end
      CMD_PARENT: begin
        if (!term_r && match) begin
          if (replies_r != CNT_MAX) begin
            replies_nxt = replies_r + CNT_W'(1);
          end
          do_explore = 1'b1;
        end
      end
      CMD_CHECK: begin
        if (!term_r && active_r && (unexp_r == '0) && pv_r
            && (pid_r == node_id_r) && (probes_r == replies_r)) begin
          res_nxt.send_valid  = 1'b1;
          res_nxt.send_kind   = KIND_TERM;
          res_nxt.send_leader = lid_r;
          term_nxt            = 1'b1;
          active_nxt          = 1'b0;
        end
      end
      default: ;
    endcase

    // lowest unexplored neighbor
    low_onehot = pre_set & (~pre_set + MAX_NODES'(1));
    low_idx    = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (low_onehot[i]) begin
        low_idx = low_idx | RANK_W'(i);
      end
    end

    unexp_nxt  = pre_set;
    probes_nxt = pre_probes;
    if (do_explore) begin
      if (pre_set != '0) begin
        unexp_nxt           = pre_set & ~low_onehot;
        res_nxt.send_valid  = 1'b1;
        res_nxt.send_kind   = KIND_PROBE;
        res_nxt.send_dest   = low_idx;
        res_nxt.send_leader = lid_nxt;
        res_nxt.send_origin = node_id_r;
        if (pre_probes != CNT_MAX) begin
          probes_nxt = pre_probes + CNT_W'(1);
        end
      end else if (pv_nxt && (pid_nxt != node_id_r)) begin
        res_nxt.send_valid  = 1'b1;
        res_nxt.send_kind   = KIND_PARENT;
        res_nxt.send_dest   = pid_nxt;
        res_nxt.send_leader = lid_nxt;
        res_nxt.send_origin = node_id_r;
      end
    end

    res_nxt.leader_known   = lv_nxt;
    res_nxt.current_leader = lid_nxt;
    res_nxt.done           = term_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r        <= 1'b0;
      lid_r       <= '0;
      pv_r        <= 1'b0;
      pid_r       <= '0;
      unexp_r     <= '0;
      probes_r    <= '0;
      replies_r   <= '0;
      active_r    <= 1'b0;
      term_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        lv_r      <= lv_nxt;
        lid_r     <= lid_nxt;
        pv_r      <= pv_nxt;
        pid_r     <= pid_nxt;
        unexp_r   <= unexp_nxt;
        probes_r  <= probes_nxt;
        replies_r <= replies_nxt;
        active_r  <= active_nxt;
        term_r    <= term_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = res_r;

endmodule
